[src/lse_pkg.sv]
package lse_pkg;

    localparam int AGE_W = 8;
    localparam int CFG_W = 16;
    localparam int SEL_W = 16;

    // Ages above this bound are evaluated at the bound.
    localparam int unsigned MAX_AGE = 255;

    // Configuration register indexes
    localparam logic [1:0] CFG_AGE_AT_HALF = 2'd0;
    localparam logic [1:0] CFG_HALF_TO_95  = 2'd1;
    localparam logic [1:0] CFG_PLATEAU     = 2'd2;

    typedef enum logic [1:0] {
        REG_ZERO    = 2'd0,
        REG_CURVE   = 2'd1,
        REG_PLATEAU = 2'd2
    } region_t;

    // Per-item sideband carried alongside the arithmetic
    typedef struct packed {
        logic [AGE_W-1:0] age;
        region_t          region;
        logic             neg;
    } lse_side_t;

    // Front end: d = a50 - age*256, lim = 5*ato95
    localparam int D_W   = 18;
    localparam int LIM_W = 19;
    localparam int MAG_W = 17;

    // First division: |t| in Q16
    localparam int DIV1_NUM_W = 34;
    localparam int DIV1_DEN_W = 16;
    localparam int DIV1_QUO_W = 20;
    localparam int DIV1_STEPS = 4;

    // Exponent path
    localparam int              PROD_W      = 39;
    localparam int              UQ_W        = 23;
    localparam int              K_W         = 7;
    localparam int              ENTRY_W     = 31;
    localparam logic [18:0]     LOG2_19_Q16 = 19'd278392;

    // Second division: alpha-weighted logistic
    localparam int DIV2_NUM_W = 47;
    localparam int DIV2_DEN_W = 32;
    localparam int DIV2_QUO_W = 18;
    localparam int DIV2_STEPS = 2;

    function automatic longint unsigned isqrt_floor(input longint unsigned x);
        longint unsigned v;
        longint unsigned r;
        longint unsigned probe;
        v     = x;
        r     = 64'd0;
        probe = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (probe > v)
            begin
                probe = probe >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (probe != 64'd0)
            begin
                if (v >= r + probe)
                begin
                    v = v - (r + probe);
                    r = (r >> 1) + probe;
                end
                else
                begin
                    r = r >> 1;
                end
                probe = probe >> 2;
            end
        end
        return r;
    endfunction

    // 2^(-idx / 2^nbits) in Q30, product of repeated square roots of one half
    function automatic logic [ENTRY_W-1:0] frac_pow2_neg(input int unsigned idx,
                                                         input int unsigned nbits);
        longint unsigned root;
        longint unsigned acc;
        root = 64'd1 << 29;
        acc  = 64'd1 << 30;
        for (int unsigned m = 1; m <= nbits; m++)
        begin
            root = isqrt_floor(root << 30);
            if (((idx >> (nbits - m)) & 1) != 0)
            begin
                acc = (acc * root + (64'd1 << 29)) >> 30;
            end
        end
        return ENTRY_W'(acc);
    endfunction

endpackage

[src/lse_front.sv]
module lse_front
    import lse_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [AGE_W-1:0]        in_age,
    input  logic signed [CFG_W-1:0] age_at_half,
    input  logic [CFG_W-1:0]        half_to_ninety_five,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [DIV1_NUM_W-1:0]   out_num,
    output logic [DIV1_DEN_W-1:0]   out_den,
    output lse_side_t               out_side
);

    logic                  vld1_reg;
    logic                  vld2_reg;
    logic                  rdy1;
    logic                  rdy2;
    logic signed [D_W-1:0] d_reg;
    logic signed [D_W-1:0] d_next;
    logic [LIM_W-1:0]      lim_reg;
    logic [LIM_W-1:0]      lim_next;
    logic [AGE_W-1:0]      age_reg;
    logic [AGE_W-1:0]      eval_age;

    logic signed [D_W+1:0] d_x;
    logic signed [D_W+1:0] lim_x;
    logic                  above;
    logic                  below;
    logic [D_W-1:0]        d_abs;
    logic [MAG_W-1:0]      mag;
    logic [DIV1_DEN_W-1:0] den_next;
    logic [DIV1_NUM_W-1:0] num_next;
    lse_side_t             side_next;

    logic [DIV1_NUM_W-1:0] num_reg;
    logic [DIV1_DEN_W-1:0] den_reg;
    lse_side_t             side_reg;

    assign rdy2     = !vld2_reg || out_ready;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: offset from a50 and the clamp bound
    always_comb
    begin
        if (32'(in_age) > MAX_AGE)
        begin
            eval_age = AGE_W'(MAX_AGE);
        end
        else
        begin
            eval_age = in_age;
        end
        d_next   = $signed({{(D_W-CFG_W){age_at_half[CFG_W-1]}}, age_at_half})
                 - $signed({2'b00, eval_age, 8'h00});
        lim_next = {1'b0, half_to_ninety_five, 2'b00} + {3'b000, half_to_ninety_five};
    end

    // Stage 2: region decision and first dividend
    always_comb
    begin
        d_x   = {{2{d_reg[D_W-1]}}, d_reg};
        lim_x = $signed({1'b0, lim_reg});
        above = d_x > lim_x;
        below = d_x < -lim_x;
        d_abs = d_reg[D_W-1] ? D_W'(-d_reg) : d_reg;
        if (above || below)
        begin
            mag = '0;
        end
        else
        begin
            mag = d_abs[MAG_W-1:0];
        end
        if (half_to_ninety_five == '0)
        begin
            den_next = DIV1_DEN_W'(1);
        end
        else
        begin
            den_next = half_to_ninety_five;
        end
        num_next = {1'b0, mag, 16'h0000} + {18'h0, 1'b0, den_next[DIV1_DEN_W-1:1]};
        side_next.age = age_reg;
        side_next.neg = d_reg[D_W-1];
        if (above)
        begin
            side_next.region = REG_ZERO;
        end
        else if (below)
        begin
            side_next.region = REG_PLATEAU;
        end
        else
        begin
            side_next.region = REG_CURVE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                vld1_reg <= in_valid;
            end
            if (rdy2)
            begin
                vld2_reg <= vld1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            d_reg   <= d_next;
            lim_reg <= lim_next;
            age_reg <= in_age;
        end
        if (rdy2 && vld1_reg)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld2_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

    a_clamped_no_mag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_side.region != REG_CURVE
            |-> out_num == DIV1_NUM_W'(out_den >> 1))
        else $error("clamped item carries a nonzero magnitude");

endmodule

[src/lse_div.sv]
module lse_div
    import lse_pkg::*;
#(
    parameter int NUM_W = 34,
    parameter int DEN_W = 16,
    parameter int QUO_W = 20,
    parameter int STEPS = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  lse_side_t        in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [QUO_W-1:0] out_quo,
    output lse_side_t        out_side
);

    localparam int STAGES = QUO_W / STEPS;
    localparam int PR_W   = DEN_W + QUO_W;

    // Partial remainder in the top DEN_W bits, dividend bits then quotient bits below
    logic [PR_W-1:0]  pr_reg   [STAGES];
    logic [DEN_W-1:0] den_reg  [STAGES];
    lse_side_t        side_reg [STAGES];
    logic             vld_reg  [STAGES];
    logic [STAGES:0]  rdy;

    function automatic logic [PR_W-1:0] div_steps(input logic [PR_W-1:0] pr,
                                                  input logic [DEN_W-1:0] den);
        logic [PR_W-1:0] acc;
        logic [DEN_W:0]  trial;
        logic            qbit;
        acc = pr;
        for (int i = 0; i < STEPS; i++)
        begin
            trial = acc[PR_W-1:QUO_W-1];
            qbit  = trial >= {1'b0, den};
            if (qbit)
            begin
                trial = trial - {1'b0, den};
            end
            acc = {trial[DEN_W-1:0], acc[QUO_W-2:0], qbit};
        end
        return acc;
    endfunction

    always_comb
    begin
        rdy[STAGES] = out_ready;
        for (int s = STAGES - 1; s >= 0; s--)
        begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < STAGES; s++)
            begin
                if (rdy[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            pr_reg[0]   <= div_steps(PR_W'(in_num), in_den);
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
        end
        for (int s = 1; s < STAGES; s++)
        begin
            if (rdy[s] && vld_reg[s-1])
            begin
                pr_reg[s]   <= div_steps(pr_reg[s-1], den_reg[s-1]);
                den_reg[s]  <= den_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[STAGES-1];
    assign out_quo   = pr_reg[STAGES-1][QUO_W-1:0];
    assign out_side  = side_reg[STAGES-1];

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pr_reg[STAGES-1][PR_W-1:QUO_W] < den_reg[STAGES-1])
        else $error("final remainder not below divisor");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_quo))
        else $error("quotient changed while stalled");

endmodule

[src/lse_exp.sv]
module lse_exp
    import lse_pkg::*;
#(
    parameter int EXP_TABLE_BITS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DIV1_QUO_W-1:0] in_tq,
    input  lse_side_t             in_side,
    input  logic [CFG_W-1:0]      alpha,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DIV2_NUM_W-1:0] out_num,
    output logic [DIV2_DEN_W-1:0] out_den,
    output lse_side_t             out_side
);

    localparam int XS       = 5;
    localparam int TBL_SIZE = 2 ** EXP_TABLE_BITS;

    logic [ENTRY_W-1:0] exp_tbl [TBL_SIZE];

    for (genvar i = 0; i < TBL_SIZE; i++)
    begin : g_tbl
        localparam logic [ENTRY_W-1:0] ENTRY = frac_pow2_neg(i, EXP_TABLE_BITS);
        assign exp_tbl[i] = ENTRY;
    end

    logic      vld_reg  [XS];
    lse_side_t side_reg [XS];
    logic [XS:0] rdy;

    logic [PROD_W-1:0]         prod_reg;
    logic [PROD_W-1:0]         prod_next;
    logic [PROD_W-1:0]         uq_full;
    logic [UQ_W-1:0]           uq;
    logic [EXP_TABLE_BITS-1:0] tbl_idx;
    logic [ENTRY_W-1:0]        entry_reg;
    logic [K_W-1:0]            k_reg;
    logic [ENTRY_W-1:0]        p_reg;
    logic [ENTRY_W-1:0]        p_next;
    logic [DIV2_DEN_W-1:0]     den3_reg;
    logic [DIV2_DEN_W-1:0]     den4_reg;
    logic [DIV2_DEN_W-1:0]     den5_reg;
    logic [DIV2_NUM_W-1:0]     num4_reg;
    logic [DIV2_NUM_W-1:0]     num4_next;
    logic [DIV2_NUM_W-1:0]     num5_reg;

    always_comb
    begin
        rdy[XS] = out_ready;
        for (int s = XS - 1; s >= 0; s--)
        begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    end

    always_comb
    begin
        prod_next = PROD_W'(in_tq) * PROD_W'(LOG2_19_Q16);
        uq_full   = prod_reg + PROD_W'(32768);
        uq        = uq_full[PROD_W-1:16];
        tbl_idx   = uq[15 -: EXP_TABLE_BITS];
        p_next    = entry_reg >> k_reg;
        if (side_reg[2].neg)
        begin
            num4_next = DIV2_NUM_W'({alpha, 30'h0});
        end
        else
        begin
            num4_next = DIV2_NUM_W'(alpha) * DIV2_NUM_W'(p_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < XS; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < XS; s++)
            begin
                if (rdy[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // multiply by log2(19)
        if (rdy[0] && in_valid)
        begin
            prod_reg    <= prod_next;
            side_reg[0] <= in_side;
        end
        // round, split into shift and fraction index, look up the fraction power
        if (rdy[1] && vld_reg[0])
        begin
            entry_reg   <= exp_tbl[tbl_idx];
            k_reg       <= uq[UQ_W-1:16];
            side_reg[1] <= side_reg[0];
        end
        // apply the integer part as a shift
        if (rdy[2] && vld_reg[1])
        begin
            p_reg       <= p_next;
            den3_reg    <= {1'b0, p_next} + {2'b01, 30'h0};
            side_reg[2] <= side_reg[1];
        end
        // scale by alpha
        if (rdy[3] && vld_reg[2])
        begin
            num4_reg    <= num4_next;
            den4_reg    <= den3_reg;
            side_reg[3] <= side_reg[2];
        end
        // add half the divisor for rounding
        if (rdy[4] && vld_reg[3])
        begin
            num5_reg    <= num4_reg + DIV2_NUM_W'(den4_reg >> 1);
            den5_reg    <= den4_reg;
            side_reg[4] <= side_reg[3];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[XS-1];
    assign out_num   = num5_reg;
    assign out_den   = den5_reg;
    assign out_side  = side_reg[XS-1];

endmodule

[src/logistic_selectivity_eval_top.sv]
// Throughput: one age per cycle while the output does not stall; the front end,
// both long-division pipelines (5 and 9 stages, 4 and 2 quotient bits per stage)
// and the exponent stages each take a new item.
// A stall at the output holds only the stages that are full; empty stages keep filling.
// Reset (rst_n, asynchronous, active low) clears every valid bit and restores
// a50 = 0, ato95 = 1.0 and alpha = 1.0; there is no clearing pass.
module logistic_selectivity_eval_top
    import lse_pkg::*;
#(
    parameter int EXP_TABLE_BITS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // ages in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] age
    // results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] age_echo, [23:8] selectivity
    output logic [1:0]  m_axis_tuser    // [1:0] region
);

    // Configuration registers; read live by the pipeline; the user must write them only while idle, not enforced here
    logic signed [CFG_W-1:0] age_at_half_reg;
    logic [CFG_W-1:0]        half_to_ninety_five_reg;
    logic [CFG_W-1:0]        plateau_level_reg;

    // Front end -> first divider
    logic                  fr_valid;
    logic                  fr_ready;
    logic [DIV1_NUM_W-1:0] fr_num;
    logic [DIV1_DEN_W-1:0] fr_den;
    lse_side_t             fr_side;

    // First divider -> exponent stages
    logic                  tq_valid;
    logic                  tq_ready;
    logic [DIV1_QUO_W-1:0] tq;
    lse_side_t             tq_side;

    // Exponent stages -> second divider
    logic                  ex_valid;
    logic                  ex_ready;
    logic [DIV2_NUM_W-1:0] ex_num;
    logic [DIV2_DEN_W-1:0] ex_den;
    lse_side_t             ex_side;

    // Second divider -> output register
    logic                  q_valid;
    logic                  q_ready;
    logic [DIV2_QUO_W-1:0] q;
    lse_side_t             q_side;

    // Output register
    logic              out_vld_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [SEL_W-1:0]  sel_next;
    logic [AGE_W-1:0]  age_out_reg;
    region_t           region_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_at_half_reg         <= '0;
            half_to_ninety_five_reg <= CFG_W'(256);
            plateau_level_reg       <= CFG_W'(16384);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_AGE_AT_HALF: age_at_half_reg         <= $signed(cfg_data);
                CFG_HALF_TO_95:  half_to_ninety_five_reg <= cfg_data;
                CFG_PLATEAU:     plateau_level_reg       <= cfg_data;
                default:         ;  // drop writes to unused indexes
            endcase
        end
    end

    // Offset from a50, clamp decision, |d| * 65536 + ato95/2
    lse_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (s_axis_tvalid),
        .in_ready            (s_axis_tready),
        .in_age              (s_axis_tdata),
        .age_at_half         (age_at_half_reg),
        .half_to_ninety_five (half_to_ninety_five_reg),
        .out_valid           (fr_valid),
        .out_ready           (fr_ready),
        .out_num             (fr_num),
        .out_den             (fr_den),
        .out_side            (fr_side)
    );

    // |t| in Q16, rounded to nearest
    lse_div #(
        .NUM_W (DIV1_NUM_W),
        .DEN_W (DIV1_DEN_W),
        .QUO_W (DIV1_QUO_W),
        .STEPS (DIV1_STEPS)
    ) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_num    (fr_num),
        .in_den    (fr_den),
        .in_side   (fr_side),
        .out_valid (tq_valid),
        .out_ready (tq_ready),
        .out_quo   (tq),
        .out_side  (tq_side)
    );

    // 2^(-|t| log2 19) in Q30, then numerator and denominator of the logistic
    lse_exp #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tq_valid),
        .in_ready  (tq_ready),
        .in_tq     (tq),
        .in_side   (tq_side),
        .alpha     (plateau_level_reg),
        .out_valid (ex_valid),
        .out_ready (ex_ready),
        .out_num   (ex_num),
        .out_den   (ex_den),
        .out_side  (ex_side)
    );

    // Selectivity on the curve, rounded to nearest
    lse_div #(
        .NUM_W (DIV2_NUM_W),
        .DEN_W (DIV2_DEN_W),
        .QUO_W (DIV2_QUO_W),
        .STEPS (DIV2_STEPS)
    ) u_div_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ex_valid),
        .in_ready  (ex_ready),
        .in_num    (ex_num),
        .in_den    (ex_den),
        .in_side   (ex_side),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_quo   (q),
        .out_side  (q_side)
    );

    // Pick the clamped value or the saturated quotient
    always_comb
    begin
        case (q_side.region)
            REG_ZERO:    sel_next = '0;
            REG_PLATEAU: sel_next = plateau_level_reg;
            REG_CURVE:
            begin
                if (|q[DIV2_QUO_W-1:SEL_W])
                begin
                    sel_next = '1;
                end
                else
                begin
                    sel_next = q[SEL_W-1:0];
                end
            end
            default:     sel_next = '0;
        endcase
    end

    // Output register: advance when empty or when the item is taken
    assign q_ready = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (q_ready)
        begin
            out_vld_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_ready && q_valid)
        begin
            sel_reg     <= sel_next;
            age_out_reg <= q_side.age;
            region_reg  <= q_side.region;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {sel_reg, age_out_reg};
    assign m_axis_tuser  = region_reg;

    a_zero_region: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == REG_ZERO |-> m_axis_tdata[23:8] == '0)
        else $error("zero-clamped item has nonzero selectivity");

endmodule

[dv/tb_logistic_selectivity_eval_top.sv]
module tb_logistic_selectivity_eval_top
    import lse_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Table resolution of the fractional power of two, shared with the block
    localparam int TABLE_BITS = 6;
    // |t| * log2(19) scale factor, Q16
    localparam longint unsigned LOG2_OF_19_Q16 = 64'd278392;
    localparam longint unsigned Q30_UNIT = 64'd1 << 30;
    // Index with no register behind it; writes to it must be dropped
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_AGES = 800;
    localparam int DRAIN_CYCLES = 40;

    // One result as it leaves the block
    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic [SEL_W-1:0] sel;
        region_t          region;
    } sel_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_AGE_AT_HALF;
    logic [15:0] cfg_data = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;   // [7:0] age_echo, [23:8] selectivity
    logic [1:0]  m_axis_tuser;   // [1:0] region

    // Shadow copy of the configuration, updated on each accepted write
    logic signed [15:0] a50_q88;
    logic [15:0]        ato95_q88;
    logic [15:0]        alpha_q214;

    // 2^(-i / 2^TABLE_BITS) in Q30
    longint unsigned frac_pow_q30 [0:(1 << TABLE_BITS) - 1];

    // Results owed by the block, oldest first
    sel_result_t awaited_sel [$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  ages_sent = 0;
    // Set for a stretch where neither side idles
    bit  steady_flow = 1'b0;

    logistic_selectivity_eval_top #(
        .EXP_TABLE_BITS (TABLE_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bit-serial floor square root, one result bit per pass
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned trial;
        r = 64'd0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= x)
            begin
                r = trial;
            end
        end
        return r;
    endfunction

    // Build the fraction table: chain of roots of one half, then a rounded product
    // over the set bits of each index, most significant bit first.
    function automatic void fill_frac_pow();
        longint unsigned roots [1:TABLE_BITS];
        longint unsigned r;
        longint unsigned acc;
        r = Q30_UNIT >> 1;
        for (int m = 1; m <= TABLE_BITS; m++)
        begin
            r = floor_sqrt(r << 30);
            roots[m] = r;
        end
        for (int i = 0; i < (1 << TABLE_BITS); i++)
        begin
            acc = Q30_UNIT;
            for (int m = 1; m <= TABLE_BITS; m++)
            begin
                if (((i >> (TABLE_BITS - m)) & 1) != 0)
                begin
                    acc = (acc * roots[m] + (Q30_UNIT >> 1)) >> 30;
                end
            end
            frac_pow_q30[i] = acc;
        end
    endfunction

    // Selectivity of one age under the current shadow configuration
    function automatic sel_result_t eval_selectivity(input logic [7:0] age);
        longint          eff_age;
        longint          age_offset;
        longint          span;
        longint unsigned mag;
        longint unsigned span_u;
        longint unsigned alpha_u;
        longint unsigned tq;
        longint unsigned uq;
        longint unsigned k;
        longint unsigned p;
        longint unsigned num;
        longint unsigned den;
        longint unsigned sel;
        bit              neg;
        sel_result_t     r;
        eff_age    = (age > MAX_AGE) ? longint'(MAX_AGE) : longint'(age);
        age_offset = longint'(a50_q88) - eff_age * 256;
        span       = 5 * longint'({1'b0, ato95_q88});
        span_u     = longint'({1'b0, ato95_q88});
        alpha_u    = longint'({1'b0, alpha_q214});
        r.age      = age;
        if (age_offset > span)
        begin
            r.sel    = '0;
            r.region = REG_ZERO;
        end
        else if (age_offset < -span)
        begin
            r.sel    = alpha_q214;
            r.region = REG_PLATEAU;
        end
        else
        begin
            neg = age_offset < 0;
            mag = neg ? longint'(-age_offset) : longint'(age_offset);
            // zero span only reaches here with a zero offset, so t = 0
            tq  = (span_u == 0) ? 64'd0 : ((mag << 16) + span_u / 2) / span_u;
            uq  = (tq * LOG2_OF_19_Q16 + 64'd32768) >> 16;
            k   = uq >> 16;
            p   = frac_pow_q30[(uq & 64'hFFFF) >> (16 - TABLE_BITS)];
            p   = (k >= 63) ? 64'd0 : (p >> k);
            den = Q30_UNIT + p;
            num = neg ? alpha_u * Q30_UNIT : alpha_u * p;
            sel = (num + den / 2) / den;
            r.sel    = (sel > 64'hFFFF) ? 16'hFFFF : sel[15:0];
            r.region = REG_CURVE;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
        begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Offer one age, idling first at random, and record its expected result on acceptance
    task automatic send_age(input logic [7:0] age);
        while (!steady_flow && $urandom_range(99) < 17)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= age;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        awaited_sel.push_back(eval_selectivity(age));
        ages_sent++;
    endtask

    // Drop the age stream and hold until every owed result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (awaited_sel.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Drop valid after each write so back-to-back writes never
    // drive the channel twice in one step
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            CFG_AGE_AT_HALF: a50_q88 = value;
            CFG_HALF_TO_95:  ato95_q88 = value;
            CFG_PLATEAU:     alpha_q214 = value;
            default:         ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_curve(input logic [15:0] a50, input logic [15:0] ato95,
                             input logic [15:0] alpha);
        write_reg(CFG_AGE_AT_HALF, a50);
        write_reg(CFG_HALF_TO_95, ato95);
        write_reg(CFG_PLATEAU, alpha);
    endtask

    // Reset values: a50 = 0, ato95 = 1.0, alpha = 1.0. Age 0 sits at t = 0, age 5 at
    // the exact lower bound, age 6 past it.
    task automatic test_reset_defaults();
        send_age(8'd0);
        send_age(8'd1);
        send_age(8'd5);
        send_age(8'd6);
        send_age(8'd255);
    endtask

    // Both exact bounds around a50 = 10.0: t = 5 and t = -5 stay on the curve
    task automatic test_exact_bounds();
        wait_drained();
        set_curve(16'd2560, 16'd256, 16'd16384);
        send_age(8'd4);
        send_age(8'd5);
        send_age(8'd10);
        send_age(8'd15);
        send_age(8'd16);
    endtask

    // Extreme register values, including the largest alpha
    task automatic test_register_extremes();
        wait_drained();
        set_curve(16'h7FFF, 16'hFFFF, 16'hFFFF);
        send_age(8'd0);
        send_age(8'd127);
        send_age(8'd128);
        send_age(8'd255);
        wait_drained();
        set_curve(16'h8000, 16'd1, 16'd1);
        send_age(8'd0);
        send_age(8'd255);
    endtask

    // Zero span: sign of d decides the clamp, d == 0 gives alpha / 2.
    // A write to the unmapped index must leave everything as it was.
    task automatic test_zero_span();
        wait_drained();
        set_curve(16'd2560, 16'd0, 16'd20000);
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        send_age(8'd9);
        send_age(8'd10);
        send_age(8'd11);
    endtask

    // Zero alpha: every value is 0 but the region still follows t
    task automatic test_zero_alpha();
        wait_drained();
        set_curve(16'd2560, 16'd512, 16'd0);
        send_age(8'd0);
        send_age(8'd10);
        send_age(8'd12);
        send_age(8'd40);
    endtask

    // Random settings per phase; most ages land near a50 so the curve is well covered
    task automatic test_random_sweeps();
        int base;
        int phase_len;
        int center;
        int spread;
        int age_pick;
        int phase_idx;
        logic [15:0] a50;
        logic [15:0] ato95;
        logic [15:0] alpha;
        base = ages_sent;
        phase_idx = 0;
        while (ages_sent - base < RANDOM_AGES)
        begin
            wait_drained();
            case ($urandom_range(5))
                0:       a50 = 16'($urandom_range(65535));
                1:       a50 = ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
                default: a50 = 16'($urandom_range(200 * 256));
            endcase
            case ($urandom_range(5))
                0:       ato95 = 16'($urandom_range(65535, 1));
                1:       ato95 = ($urandom_range(1)) ? 16'd1 : 16'hFFFF;
                default: ato95 = 16'($urandom_range(24 * 256, 16));
            endcase
            case ($urandom_range(4))
                0:       alpha = ($urandom_range(1)) ? 16'd1 : 16'hFFFF;
                default: alpha = 16'($urandom_range(65535, 1));
            endcase
            set_curve(a50, ato95, alpha);
            // one long phase runs with no idling on either side
            steady_flow = (phase_idx == 3);
            phase_len = steady_flow ? 150 : $urandom_range(120, 40);
            center = $signed(a50) >>> 8;
            center = (center < 0) ? 0 : ((center > 255) ? 255 : center);
            spread = ((int'(ato95) * 6) >> 8) + 2;
            spread = (spread > 255) ? 255 : spread;
            for (int n = 0; n < phase_len; n++)
            begin
                if ($urandom_range(99) < 60)
                begin
                    age_pick = center + $urandom_range(2 * spread) - spread;
                    age_pick = (age_pick < 0) ? 0 : ((age_pick > 255) ? 255 : age_pick);
                end
                else
                begin
                    age_pick = $urandom_range(255);
                end
                send_age(age_pick[7:0]);
            end
            steady_flow = 1'b0;
            phase_idx++;
        end
    endtask

    // Result sink: compare each accepted result with the oldest owed one, stall at random
    always @(posedge clk)
    begin
        sel_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_sel.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result age %0d", m_axis_tdata[7:0]));
                end
                else
                begin
                    want = awaited_sel.pop_front();
                    if (m_axis_tdata[7:0] !== want.age)
                    begin
                        report_mismatch($sformatf("age_echo %0d, want %0d",
                                                  m_axis_tdata[7:0], want.age));
                    end
                    if (m_axis_tdata[23:8] !== want.sel)
                    begin
                        report_mismatch($sformatf("age %0d: selectivity %0d, want %0d",
                                                  want.age, m_axis_tdata[23:8], want.sel));
                    end
                    if (m_axis_tuser !== want.region)
                    begin
                        report_mismatch($sformatf("age %0d: region %0d, want %0d",
                                                  want.age, m_axis_tuser, want.region));
                    end
                end
            end
            m_axis_tready <= steady_flow || ($urandom_range(99) >= 17);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count,
                     awaited_sel.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        a50_q88    = 16'sd0;
        ato95_q88  = 16'd256;
        alpha_q214 = 16'd16384;
        fill_frac_pow();
        // hold reset, then release on an edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_exact_bounds();
        test_register_extremes();
        test_zero_span();
        test_zero_alpha();
        test_random_sweeps();

        wait_drained();
        // let the pipeline run dry so stray extra results show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_sel.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
